// File: rtl/whc_pkg.sv
// ----------------------------------------------------------------------------
// whc_pkg: shared types and constants for the wire crossing fit
// Fixed widths of the fit datapath, the sequencer states, the register
// indexes and the request and response structs of the shared divider.
// ----------------------------------------------------------------------------
package whc_pkg;

  // Direction fraction bits and accumulator widths
  localparam int DFB      = 14;
  localparam int SUM_W    = 34;
  localparam int CROSS_W  = 56;
  localparam int RED_W    = SUM_W - DFB;
  localparam int REDX_W   = CROSS_W - DFB;
  localparam int SPLIT_W  = REDX_W / 2;

  // Shared multiplier ports
  localparam int MA_W     = 36;
  localparam int MB_W     = 22;
  localparam int P_W      = MA_W + MB_W;

  // Solve datapath
  localparam int ACC_W    = 62;
  localparam int DET_W    = 41;
  localparam int RES_W    = 21;

  // Shared divider
  localparam int DIVN_W   = 64;
  localparam int DIVD_W   = 48;

  // One stored hit: pos_x, pos_y, dir_x, dir_y, err_sq
  localparam int HIT_W    = 17 + 17 + 16 + 16 + 24;

  typedef enum logic [1:0] {
    CFG_CORE_RADIUS = 2'd0,
    CFG_SIGMA_R     = 2'd1
  } whc_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_SOLVE,
    ST_DIVX,
    ST_DIVY,
    ST_SIG,
    ST_HIT,
    ST_DIVA,
    ST_DIVC,
    ST_FINISH
  } whc_state_e;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] num;
    logic [DIVD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/whc_ram.sv
// ----------------------------------------------------------------------------
// whc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module whc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/whc_mul.sv
// ----------------------------------------------------------------------------
// whc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module whc_mul (
  input  logic                          clk_i,
  input  logic signed [whc_pkg::MA_W-1:0] a_i,
  input  logic signed [whc_pkg::MB_W-1:0] b_i,
  output logic signed [whc_pkg::P_W-1:0]  prod_o
);

  import whc_pkg::*;

  logic signed [P_W-1:0] prod_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(a_i) * P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/whc_div.sv
// ----------------------------------------------------------------------------
// whc_div: shared iterative unsigned divider
// Restoring division, one quotient bit a cycle; done pulses with the quotient.
// ----------------------------------------------------------------------------
module whc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  whc_pkg::div_req_t req_i,
  output whc_pkg::div_rsp_t rsp_o
);

  import whc_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] rem_q;
  logic [DIVN_W-1:0] quo_q;
  logic [DIVD_W-1:0] den_q;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;
  logic              ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[DIVN_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Iterate one bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVN_W);
      rem_q  <= '0;
      quo_q  <= req_i.num;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo_q  <= {quo_q[DIVN_W-2:0], ge};
      cnt_q  <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: rtl/wire_hits_center_and_chi2.sv
// ----------------------------------------------------------------------------
// wire_hits_center_and_chi2: least-squares crossing point of wire hits
// Collects hits, solves the crossing point on the last one and sums two chi2s.
// ----------------------------------------------------------------------------
// Input channel: one hit per request (position, direction, error, last flag).
// A request is taken while in_stall_o is low; the block stalls while it works.
// A hit that is not last is stored and added to the sums in 8 multiplier steps; a
// hit arriving on a full store is not stored and sets the overflow flag.
// On the last hit the block runs the solve (11 multiplier steps), two centre
// divisions and sigma squared, and then per stored hit the residual steps and
// two chi2 divisions, along and across, before the result is handed over.
// A degenerate set skips the divisions and the chi2 walk.
// The result request is held in an output register until out_stall_i is low;
// a new set may be loaded meanwhile, and a finished set waits there.
// Configuration writes (core_radius, sigma_r) are taken in any cycle.
// Reset clears the sums, count and flags and loads both registers with 192;
// the hit store is not cleared.
// ----------------------------------------------------------------------------
module wire_hits_center_and_chi2 #(
  parameter int MAX_HITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // input hits
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic [23:0]        err_sq_i,
  input  logic               last_hit_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [16:0] center_x_o,
  output logic signed [16:0] center_y_o,
  output logic [4:0]         hit_count_o,
  output logic [31:0]        chi2_along_o,
  output logic [31:0]        chi2_across_o,
  output logic               degenerate_o,
  output logic               overflow_o
);

  import whc_pkg::*;

  localparam int AW = $clog2(MAX_HITS);
  localparam int CW = $clog2(MAX_HITS + 1);

  // Rounded magnitude of a direction-scaled residual
  function automatic logic [RES_W-1:0] rnd_mag(input logic signed [34:0] s);
    logic [34:0] m;
    m = s[34] ? 35'(-s) : 35'(s);
    return RES_W'((36'(m) + (36'd1 << (DFB - 1))) >> DFB);
  endfunction

  // Saturate a rounded quotient into the centre range
  function automatic logic signed [16:0] sat_center(input logic [DIVN_W-1:0] q,
                                                    input logic neg);
    if (neg) begin
      return (q > 64'd65536) ? 17'h10000 : 17'(-q);
    end
    return (q > 64'd65535) ? 17'h0FFFF : 17'(q);
  endfunction

  // Saturating chi2 accumulate
  function automatic logic [31:0] sat_add(input logic [31:0] a,
                                          input logic [DIVN_W-1:0] q);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, q[31:0]};
    return ((|q[DIVN_W-1:32]) || s[32]) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  whc_state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  logic [15:0] core_q, core_d, sigma_q, sigma_d;

  logic signed [16:0] hpx_q, hpx_d, hpy_q, hpy_d;
  logic signed [15:0] hnx_q, hnx_d, hny_q, hny_d;
  logic               hlast_q, hlast_d;

  logic signed [SUM_W-1:0]   sxx_q, sxx_d, sxy_q, sxy_d, syy_q, syy_d;
  logic signed [CROSS_W-1:0] sxc_q, sxc_d, syc_q, syc_d;
  logic signed [SUM_W-1:0]   nr_q, nr_d;
  logic [CW-1:0]             count_q, count_d, idx_q, idx_d;
  logic                      ovf_q, ovf_d;

  logic signed [ACC_W-1:0] acc_q, acc_d, numx_q, numx_d, numy_q, numy_d;
  logic signed [DET_W-1:0] d_q, d_d;
  logic signed [16:0]      cx_q, cx_d, cy_q, cy_d;
  logic [31:0]             along_q, along_d, across_q, across_d, s2_q, s2_d;
  logic [RES_W-1:0]        wm_q, wm_d, drr_q, drr_d;
  logic                    degen_q, degen_d;

  logic signed [16:0] ocx_q, ocx_d, ocy_q, ocy_d;
  logic [4:0]         ocnt_q, ocnt_d;
  logic [31:0]        oalong_q, oalong_d, oacross_q, oacross_d;
  logic               odegen_q, odegen_d, oovf_q, oovf_d, ovalid_q, ovalid_d;

  // Shared units
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Store
  logic              ram_we;
  logic [HIT_W-1:0]  ram_wdata, ram_rdata;
  logic signed [16:0] r_px, r_py;
  logic signed [15:0] r_nx, r_ny;
  logic [23:0]        r_e;

  // Reduced sums and split halves for the solve
  logic signed [RED_W-1:0]   red_a, red_b, red_c;
  logic signed [REDX_W-1:0]  red_p, red_q;
  logic signed [MB_W-1:0]    pl, ql;
  logic signed [SPLIT_W-1:0] ph, qh;
  logic [DET_W-1:0]          dmag;
  logic [ACC_W-1:0]          numx_mag, numy_mag;

  // Per-hit residual terms
  logic signed [17:0] dx, dy;
  logic [RES_W-1:0]   wr, nm;
  logic [32:0]        den_al;
  logic [31:0]        s2p;

  whc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  whc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  whc_ram #(
    .WIDTH (HIT_W),
    .DEPTH (MAX_HITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {pos_x_i, pos_y_i, dir_x_i, dir_y_i, err_sq_i};
  assign r_px = ram_rdata[89:73];
  assign r_py = ram_rdata[72:56];
  assign r_nx = ram_rdata[55:40];
  assign r_ny = ram_rdata[39:24];
  assign r_e  = ram_rdata[23:0];

  // Floor shift the sums and split the cross sums for the multiplier
  assign red_a = sxx_q[SUM_W-1:DFB];
  assign red_b = sxy_q[SUM_W-1:DFB];
  assign red_c = syy_q[SUM_W-1:DFB];
  assign red_p = sxc_q[CROSS_W-1:DFB];
  assign red_q = syc_q[CROSS_W-1:DFB];
  assign pl    = $signed({1'b0, red_p[SPLIT_W-1:0]});
  assign ql    = $signed({1'b0, red_q[SPLIT_W-1:0]});
  assign ph    = red_p[REDX_W-1:SPLIT_W];
  assign qh    = red_q[REDX_W-1:SPLIT_W];

  assign dmag     = d_q[DET_W-1] ? DET_W'(-d_q) : DET_W'(d_q);
  assign numx_mag = numx_q[ACC_W-1] ? ACC_W'(-numx_q) : ACC_W'(numx_q);
  assign numy_mag = numy_q[ACC_W-1] ? ACC_W'(-numy_q) : ACC_W'(numy_q);

  assign dx     = 18'(r_px) - 18'(cx_q);
  assign dy     = 18'(r_py) - 18'(cy_q);
  assign wr     = rnd_mag(35'(acc_q) + 35'(prod));
  assign nm     = rnd_mag(35'(acc_q) - 35'(prod));
  assign den_al = 33'(s2_q) + 33'(r_e);
  assign s2p    = (s2_q == 32'd0) ? 32'd1 : s2_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Sequencer: next state, shared unit operands and datapath updates
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    core_d    = core_q;
    sigma_d   = sigma_q;
    hpx_d     = hpx_q;
    hpy_d     = hpy_q;
    hnx_d     = hnx_q;
    hny_d     = hny_q;
    hlast_d   = hlast_q;
    sxx_d     = sxx_q;
    sxy_d     = sxy_q;
    syy_d     = syy_q;
    sxc_d     = sxc_q;
    syc_d     = syc_q;
    nr_d      = nr_q;
    count_d   = count_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    acc_d     = acc_q;
    numx_d    = numx_q;
    numy_d    = numy_q;
    d_d       = d_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    along_d   = along_q;
    across_d  = across_q;
    s2_d      = s2_q;
    wm_d      = wm_q;
    drr_d     = drr_q;
    degen_d   = degen_q;
    ocx_d     = ocx_q;
    ocy_d     = ocy_q;
    ocnt_d    = ocnt_q;
    oalong_d  = oalong_q;
    oacross_d = oacross_q;
    odegen_d  = odegen_q;
    oovf_d    = oovf_q;
    ovalid_d  = ovalid_q && out_stall_i;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    ram_we    = 1'b0;

    // Register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CORE_RADIUS: core_d  = cfg_data_i;
        CFG_SIGMA_R:     sigma_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        // Take a hit: store it, or flag the overflow when full
        if (in_valid_i) begin
          hpx_d   = pos_x_i;
          hpy_d   = pos_y_i;
          hnx_d   = dir_x_i;
          hny_d   = dir_y_i;
          hlast_d = last_hit_i;
          step_d  = '0;
          if (count_q < CW'(MAX_HITS)) begin
            ram_we  = 1'b1;
            state_d = ST_ACC;
          end else begin
            ovf_d = 1'b1;
            if (last_hit_i) begin
              state_d = ST_SOLVE;
            end
          end
        end
      end

      ST_ACC: begin
        // Add the hit's direction products to the sums
        step_d = step_q + 1'b1;
        case (step_q)
          4'd0: begin
            mul_a = MA_W'(hpx_q);
            mul_b = MB_W'(hny_q);
          end
          4'd1: begin
            nr_d  = SUM_W'(prod);
            mul_a = MA_W'(hpy_q);
            mul_b = MB_W'(hnx_q);
          end
          4'd2: begin
            nr_d  = nr_q - SUM_W'(prod);
            mul_a = MA_W'(hnx_q);
            mul_b = MB_W'(hnx_q);
          end
          4'd3: begin
            sxx_d = sxx_q + SUM_W'(prod);
            mul_a = MA_W'(hnx_q);
            mul_b = MB_W'(hny_q);
          end
          4'd4: begin
            sxy_d = sxy_q + SUM_W'(prod);
            mul_a = MA_W'(hny_q);
            mul_b = MB_W'(hny_q);
          end
          4'd5: begin
            syy_d = syy_q + SUM_W'(prod);
            mul_a = MA_W'(nr_q);
            mul_b = MB_W'(hnx_q);
          end
          4'd6: begin
            sxc_d = sxc_q + CROSS_W'(prod);
            mul_a = MA_W'(nr_q);
            mul_b = MB_W'(hny_q);
          end
          default: begin
            syc_d   = syc_q + CROSS_W'(prod);
            count_d = count_q + 1'b1;
            step_d  = '0;
            state_d = hlast_q ? ST_SOLVE : ST_IDLE;
          end
        endcase
      end

      ST_SOLVE: begin
        // Determinant and both numerators from partial products
        step_d = step_q + 1'b1;
        case (step_q)
          4'd0: begin
            along_d  = '0;
            across_d = '0;
            cx_d     = '0;
            cy_d     = '0;
            mul_a    = MA_W'(red_a);
            mul_b    = MB_W'(red_c);
          end
          4'd1: begin
            acc_d = ACC_W'(prod);
            mul_a = MA_W'(red_b);
            mul_b = MB_W'(red_b);
          end
          4'd2: begin
            d_d   = DET_W'(acc_q - ACC_W'(prod));
            mul_a = MA_W'(red_a);
            mul_b = ql;
          end
          4'd3: begin
            acc_d = ACC_W'(prod);
            mul_a = MA_W'(red_a);
            mul_b = MB_W'(qh);
          end
          4'd4: begin
            acc_d = acc_q + (ACC_W'(prod) <<< SPLIT_W);
            mul_a = MA_W'(red_b);
            mul_b = pl;
          end
          4'd5: begin
            acc_d = acc_q - ACC_W'(prod);
            mul_a = MA_W'(red_b);
            mul_b = MB_W'(ph);
          end
          4'd6: begin
            numx_d = acc_q - (ACC_W'(prod) <<< SPLIT_W);
            mul_a  = MA_W'(red_b);
            mul_b  = ql;
          end
          4'd7: begin
            acc_d = ACC_W'(prod);
            mul_a = MA_W'(red_b);
            mul_b = MB_W'(qh);
          end
          4'd8: begin
            acc_d = acc_q + (ACC_W'(prod) <<< SPLIT_W);
            mul_a = MA_W'(red_c);
            mul_b = pl;
          end
          4'd9: begin
            acc_d = acc_q - ACC_W'(prod);
            mul_a = MA_W'(red_c);
            mul_b = MB_W'(ph);
          end
          default: begin
            numy_d  = acc_q - (ACC_W'(prod) <<< SPLIT_W);
            degen_d = (d_q == '0);
            step_d  = '0;
            state_d = (d_q == '0) ? ST_FINISH : ST_DIVX;
          end
        endcase
      end

      ST_DIVX: begin
        // Round and divide for the x coordinate
        if (step_q == 4'd0) begin
          div_req.start = 1'b1;
          div_req.num   = DIVN_W'(numx_mag) + DIVN_W'(dmag >> 1);
          div_req.den   = DIVD_W'(dmag);
          step_d        = 4'd1;
        end else if (div_rsp.done) begin
          cx_d    = sat_center(div_rsp.quo, numx_q[ACC_W-1] ^ d_q[DET_W-1]);
          step_d  = '0;
          state_d = ST_DIVY;
        end
      end

      ST_DIVY: begin
        // Round and divide for the y coordinate
        if (step_q == 4'd0) begin
          div_req.start = 1'b1;
          div_req.num   = DIVN_W'(numy_mag) + DIVN_W'(dmag >> 1);
          div_req.den   = DIVD_W'(dmag);
          step_d        = 4'd1;
        end else if (div_rsp.done) begin
          cy_d    = sat_center(div_rsp.quo, numy_q[ACC_W-1] ^ d_q[DET_W-1]);
          step_d  = '0;
          state_d = ST_SIG;
        end
      end

      ST_SIG: begin
        // Square sigma_r once for the whole walk
        if (step_q == 4'd0) begin
          mul_a  = $signed({20'd0, sigma_q});
          mul_b  = $signed({6'd0, sigma_q});
          step_d = 4'd1;
        end else begin
          s2_d    = prod[31:0];
          idx_d   = '0;
          step_d  = '0;
          state_d = (count_q != '0) ? ST_HIT : ST_FINISH;
        end
      end

      ST_HIT: begin
        // Residuals of one stored hit, then launch the along division
        step_d = step_q + 1'b1;
        case (step_q)
          4'd0: ;
          4'd1: begin
            mul_a = MA_W'(dx);
            mul_b = MB_W'(r_nx);
          end
          4'd2: begin
            acc_d = ACC_W'(prod);
            mul_a = MA_W'(dy);
            mul_b = MB_W'(r_ny);
          end
          4'd3: begin
            wm_d  = wr;
            mul_a = MA_W'(dx);
            mul_b = MB_W'(r_ny);
          end
          4'd4: begin
            acc_d = ACC_W'(prod);
            mul_a = MA_W'(dy);
            mul_b = MB_W'(r_nx);
          end
          4'd5: begin
            drr_d = (nm > RES_W'(core_q)) ? (nm - RES_W'(core_q)) : '0;
            mul_a = $signed({15'd0, wm_q});
            mul_b = $signed({1'b0, wm_q});
          end
          4'd6: begin
            div_req.start = 1'b1;
            div_req.num   = {6'd0, prod[49:0], 8'd0};
            div_req.den   = (den_al == 33'd0) ? DIVD_W'(1) : DIVD_W'(den_al);
            mul_a         = $signed({15'd0, drr_q});
            mul_b         = $signed({1'b0, drr_q});
          end
          default: begin
            acc_d   = $signed({4'd0, prod[49:0], 8'd0});
            step_d  = '0;
            state_d = ST_DIVA;
          end
        endcase
      end

      ST_DIVA: begin
        // Accumulate the along term and launch the across division
        if (div_rsp.done) begin
          along_d       = sat_add(along_q, div_rsp.quo);
          div_req.start = 1'b1;
          div_req.num   = DIVN_W'(acc_q);
          div_req.den   = DIVD_W'(s2p);
          state_d       = ST_DIVC;
        end
      end

      ST_DIVC: begin
        // Accumulate the across term and advance to the next hit
        if (div_rsp.done) begin
          across_d = sat_add(across_q, div_rsp.quo);
          idx_d    = idx_q + 1'b1;
          step_d   = '0;
          state_d  = (CW'(idx_q + 1'b1) < count_q) ? ST_HIT : ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Hand the result over once the output register is free
        if (!(ovalid_q && out_stall_i)) begin
          ocx_d     = cx_q;
          ocy_d     = cy_q;
          ocnt_d    = 5'(count_q);
          oalong_d  = along_q;
          oacross_d = across_q;
          odegen_d  = degen_q;
          oovf_d    = ovf_q;
          ovalid_d  = 1'b1;
          sxx_d     = '0;
          sxy_d     = '0;
          syy_d     = '0;
          sxc_d     = '0;
          syc_d     = '0;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      core_q    <= 16'd192;
      sigma_q   <= 16'd192;
      hpx_q     <= '0;
      hpy_q     <= '0;
      hnx_q     <= '0;
      hny_q     <= '0;
      hlast_q   <= 1'b0;
      sxx_q     <= '0;
      sxy_q     <= '0;
      syy_q     <= '0;
      sxc_q     <= '0;
      syc_q     <= '0;
      nr_q      <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      acc_q     <= '0;
      numx_q    <= '0;
      numy_q    <= '0;
      d_q       <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      along_q   <= '0;
      across_q  <= '0;
      s2_q      <= '0;
      wm_q      <= '0;
      drr_q     <= '0;
      degen_q   <= 1'b0;
      ocx_q     <= '0;
      ocy_q     <= '0;
      ocnt_q    <= '0;
      oalong_q  <= '0;
      oacross_q <= '0;
      odegen_q  <= 1'b0;
      oovf_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      step_q    <= step_d;
      core_q    <= core_d;
      sigma_q   <= sigma_d;
      hpx_q     <= hpx_d;
      hpy_q     <= hpy_d;
      hnx_q     <= hnx_d;
      hny_q     <= hny_d;
      hlast_q   <= hlast_d;
      sxx_q     <= sxx_d;
      sxy_q     <= sxy_d;
      syy_q     <= syy_d;
      sxc_q     <= sxc_d;
      syc_q     <= syc_d;
      nr_q      <= nr_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
      acc_q     <= acc_d;
      numx_q    <= numx_d;
      numy_q    <= numy_d;
      d_q       <= d_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      along_q   <= along_d;
      across_q  <= across_d;
      s2_q      <= s2_d;
      wm_q      <= wm_d;
      drr_q     <= drr_d;
      degen_q   <= degen_d;
      ocx_q     <= ocx_d;
      ocy_q     <= ocy_d;
      ocnt_q    <= ocnt_d;
      oalong_q  <= oalong_d;
      oacross_q <= oacross_d;
      odegen_q  <= odegen_d;
      oovf_q    <= oovf_d;
      ovalid_q  <= ovalid_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign center_x_o    = ocx_q;
  assign center_y_o    = ocy_q;
  assign hit_count_o   = ocnt_q;
  assign chi2_along_o  = oalong_q;
  assign chi2_across_o = oacross_q;
  assign degenerate_o  = odegen_q;
  assign overflow_o    = oovf_q;

  // The fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_HITS))
    else $error("hit count beyond store depth");

  // A divider result only arrives while the sequencer waits for one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVX || state_q == ST_DIVY ||
                      state_q == ST_DIVA || state_q == ST_DIVC))
    else $error("divider result outside a division wait");

  // A degenerate set reports empty chi2 sums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (chi2_along_o == '0 && chi2_across_o == '0))
    else $error("degenerate result with chi2 terms");

endmodule
